// ===== hdl/assert_macros.svh =====
// assertion macros used by the cipher top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/mrc4_pkg.sv =====
// shared types and constants of the modified rc4 keystream cipher
package mrc4_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY_LEN_W  = 6;
  localparam int unsigned PERM_DEPTH = 256;

  localparam logic [DATA_W-1:0]    SBOX_INIT_XOR = 8'h5A;
  localparam logic [DATA_W-1:0]    KSA_ADD       = 8'h7F;
  localparam logic [DATA_W-1:0]    LAST_INDEX    = 8'hFF;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd4;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_INIT  = 12'b0000_0000_0010,
    ST_KS_RI = 12'b0000_0000_0100,
    ST_KS_RJ = 12'b0000_0000_1000,
    ST_KS_WI = 12'b0000_0001_0000,
    ST_KS_WJ = 12'b0000_0010_0000,
    ST_PR_RX = 12'b0000_0100_0000,
    ST_PR_RY = 12'b0000_1000_0000,
    ST_PR_WX = 12'b0001_0000_0000,
    ST_PR_WY = 12'b0010_0000_0000,
    ST_PR_RK = 12'b0100_0000_0000,
    ST_PR_OUT = 12'b1000_0000_0000
  } state_e;

endpackage

// ===== hdl/mrc4_if.sv =====
// valid/ready channel interfaces for data in, data out and configuration
interface mrc4_in_if;
  logic                         valid;
  logic                         ready;
  logic [mrc4_pkg::DATA_W-1:0]  data_in;
  logic                         first_of_buffer;

  modport source (output valid, data_in, first_of_buffer, input ready);
  modport sink   (input valid, data_in, first_of_buffer, output ready);
endinterface

interface mrc4_out_if;
  logic                         valid;
  logic                         ready;
  logic [mrc4_pkg::DATA_W-1:0]  data_out;

  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

interface mrc4_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mrc4_pkg::CFG_IDX_W-1:0]   index;
  logic [mrc4_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mrc4_ram.sv =====
// generic single write port ram with registered read
module mrc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/modified_rc4_keystream_cipher_unit.sv =====
// top level of the modified rc4 keystream cipher
//
// in_i carries one data byte and a first_of_buffer flag per transfer; out_o
// returns exactly one byte per input byte, the input XOR the keystream byte.
// cfg_i writes key_length (index 0) and key_word_0..3 (index 1..4); it is
// always ready; writes are to be made only while the block is idle, which
// the block does not enforce. a byte is taken only when the sequencer is
// idle. without rescheduling the byte passes through pr_rx, pr_ry, pr_wx,
// pr_wy, pr_rk and pr_out, where the result is loaded, and the sequencer
// returns to idle for the next byte. a first byte of a buffer, or any byte
// while no table has been built, first fills all 256 table entries and runs
// key scheduling (read i, read j, write i, write j per entry); the single
// permutation ram serves one read or one write per cycle, read registered.
// a finished byte waits in the output register; while it is not taken, the
// next byte may be accepted and worked on, and stops only at its own load.
// reset clears the sequencer, indices, output valid and the key registers
// (length 16, key 0); the table contents are left as they are and are
// rebuilt before first use.
`include "assert_macros.svh"

module modified_rc4_keystream_cipher_unit #(
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrc4_in_if.sink    in_i,
  mrc4_out_if.source out_o,
  mrc4_cfg_if.sink   cfg_i
);

  localparam int unsigned KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [mrc4_pkg::KEY_LEN_W-1:0] MAX_LEN =
    mrc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
  localparam int unsigned AW = $clog2(mrc4_pkg::PERM_DEPTH);

  mrc4_pkg::state_e state_q, state_d;

  logic [mrc4_pkg::KEY_LEN_W-1:0] key_len_q, key_len_d, len_eff;
  logic [mrc4_pkg::DATA_W-1:0]    key_q [MAX_KEY_BYTES];
  logic [mrc4_pkg::DATA_W-1:0]    key_d [MAX_KEY_BYTES];
  logic [1:0]                     word_sel;

  logic [7:0]     i_q, i_d, j_q, j_d, x_q, x_d, y_q, y_d;
  logic [7:0]     si_q, si_d, sj_q, sj_d, data_q, data_d;
  logic [KIW-1:0] kidx_q, kidx_d;
  logic           tready_q, tready_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     data_out_q, data_out_d;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic [7:0]     j_calc, y_calc;
  logic           in_xfer, out_xfer, out_free;

  assign in_i.ready     = (state_q == mrc4_pkg::ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = data_out_q;

  assign in_xfer  = in_i.valid & in_i.ready;
  assign out_xfer = out_valid_q & out_o.ready;
  assign out_free = !out_valid_q | out_o.ready;

  // effective key length, zero as one and saturated at the key storage
  always_comb begin
    if (key_len_q == '0) begin
      len_eff = mrc4_pkg::KEY_LEN_W'(1);
    end else if (key_len_q > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = key_len_q;
    end
  end

  // configuration writes
  always_comb begin
    key_len_d = key_len_q;
    key_d     = key_q;
    word_sel  = 2'(cfg_i.index - mrc4_pkg::CFG_KEY_WORD_0);
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        mrc4_pkg::CFG_KEY_LENGTH: begin
          key_len_d = cfg_i.data[mrc4_pkg::KEY_LEN_W-1:0];
        end
        mrc4_pkg::CFG_KEY_WORD_0, mrc4_pkg::CFG_KEY_WORD_1,
        mrc4_pkg::CFG_KEY_WORD_2, mrc4_pkg::CFG_KEY_WORD_3: begin
          for (int k = 0; k < MAX_KEY_BYTES; k++) begin
            if (2'(k >> 3) == word_sel) begin
              key_d[k] = cfg_i.data[8*(k & 7) +: 8];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign j_calc = j_q + ram_rdata + key_q[kidx_q] + mrc4_pkg::KSA_ADD;
  assign y_calc = y_q + ram_rdata;

  // single ram port schedule
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = si_q + sj_q;
    ram_wdata = si_q;
    case (state_q)
      mrc4_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = i_q;
        ram_wdata = i_q ^ mrc4_pkg::SBOX_INIT_XOR;
      end
      mrc4_pkg::ST_KS_RI: ram_addr = i_q;
      mrc4_pkg::ST_KS_RJ: ram_addr = j_calc;
      mrc4_pkg::ST_KS_WI: begin
        ram_we    = 1'b1;
        ram_addr  = i_q;
        ram_wdata = ram_rdata;
      end
      mrc4_pkg::ST_KS_WJ: begin
        ram_we   = 1'b1;
        ram_addr = j_q;
      end
      mrc4_pkg::ST_PR_RX: ram_addr = x_q + 8'd1;
      mrc4_pkg::ST_PR_RY: ram_addr = y_calc;
      mrc4_pkg::ST_PR_WX: begin
        ram_we    = 1'b1;
        ram_addr  = x_q;
        ram_wdata = ram_rdata;
      end
      mrc4_pkg::ST_PR_WY: begin
        ram_we   = 1'b1;
        ram_addr = y_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    x_d         = x_q;
    y_d         = y_q;
    si_d        = si_q;
    sj_d        = sj_q;
    data_d      = data_q;
    kidx_d      = kidx_q;
    tready_d    = tready_q;
    out_valid_d = out_valid_q & !out_xfer;
    data_out_d  = data_out_q;
    case (state_q)
      mrc4_pkg::ST_IDLE: begin
        if (in_xfer) begin
          data_d = in_i.data_in;
          if (in_i.first_of_buffer || !tready_q) begin
            i_d     = '0;
            state_d = mrc4_pkg::ST_INIT;
          end else begin
            state_d = mrc4_pkg::ST_PR_RX;
          end
        end
      end
      mrc4_pkg::ST_INIT: begin
        i_d = i_q + 8'd1;
        if (i_q == mrc4_pkg::LAST_INDEX) begin
          j_d     = '0;
          kidx_d  = '0;
          state_d = mrc4_pkg::ST_KS_RI;
        end
      end
      mrc4_pkg::ST_KS_RI: state_d = mrc4_pkg::ST_KS_RJ;
      mrc4_pkg::ST_KS_RJ: begin
        si_d    = ram_rdata;
        j_d     = j_calc;
        state_d = mrc4_pkg::ST_KS_WI;
      end
      mrc4_pkg::ST_KS_WI: state_d = mrc4_pkg::ST_KS_WJ;
      mrc4_pkg::ST_KS_WJ: begin
        i_d = i_q + 8'd1;
        if (mrc4_pkg::KEY_LEN_W'(kidx_q) + mrc4_pkg::KEY_LEN_W'(1) == len_eff) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KIW'(1);
        end
        if (i_q == mrc4_pkg::LAST_INDEX) begin
          x_d      = '0;
          y_d      = '0;
          tready_d = 1'b1;
          state_d  = mrc4_pkg::ST_PR_RX;
        end else begin
          state_d = mrc4_pkg::ST_KS_RI;
        end
      end
      mrc4_pkg::ST_PR_RX: begin
        x_d     = x_q + 8'd1;
        state_d = mrc4_pkg::ST_PR_RY;
      end
      mrc4_pkg::ST_PR_RY: begin
        si_d    = ram_rdata;
        y_d     = y_calc;
        state_d = mrc4_pkg::ST_PR_WX;
      end
      mrc4_pkg::ST_PR_WX: begin
        sj_d    = ram_rdata;
        state_d = mrc4_pkg::ST_PR_WY;
      end
      mrc4_pkg::ST_PR_WY: state_d = mrc4_pkg::ST_PR_RK;
      mrc4_pkg::ST_PR_RK: state_d = mrc4_pkg::ST_PR_OUT;
      mrc4_pkg::ST_PR_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          data_out_d  = data_q ^ ram_rdata;
          state_d     = mrc4_pkg::ST_IDLE;
        end
      end
      default: state_d = mrc4_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrc4_pkg::ST_IDLE;
      key_len_q   <= mrc4_pkg::KEY_LEN_RESET;
      key_q       <= '{default: '0};
      i_q         <= '0;
      j_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      kidx_q      <= '0;
      tready_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_len_q   <= key_len_d;
      key_q       <= key_d;
      i_q         <= i_d;
      j_q         <= j_d;
      x_q         <= x_d;
      y_q         <= y_d;
      kidx_q      <= kidx_d;
      tready_q    <= tready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    data_q     <= data_d;
    data_out_q <= data_out_d;
  end

  mrc4_ram #(
    .WIDTH (8),
    .DEPTH (mrc4_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  `ASSERT_PROP(a_gen_needs_table, clk_i, rst_ni,
               (state_q == mrc4_pkg::ST_PR_RX) |-> tready_q,
               "keystream generation started without a scheduled table")
  `ASSERT_PROP(a_out_loaded, clk_i, rst_ni,
               (state_q == mrc4_pkg::ST_PR_OUT && !out_valid_q) |=> out_valid_q,
               "finished byte not loaded into the output register")
  `ASSERT_PROP(a_out_source, clk_i, rst_ni,
               $rose(out_valid_q) |-> ($past(state_q) == mrc4_pkg::ST_PR_OUT),
               "output valid raised outside the output load")
  `ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni,
                in_xfer && (state_q != mrc4_pkg::ST_IDLE),
                "input transfer while the sequencer is busy")

endmodule
